FILE: src/lfu_pkg.sv
// Shared types and constants for the LFU replacement block with LRU tie-break.
package lfu_pkg;

  localparam int CMD_W   = 2;
  localparam int SET_W   = 6;
  localparam int WAYF_W  = 4;
  localparam int COUNT_W = 32;
  localparam int STAMP_W = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_VICTIM = 2'd0,
    CMD_FILL   = 2'd1,
    CMD_UPDATE = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_FINISH,
    ST_FILL,
    ST_READ,
    ST_MODIFY
  } state_e;

  typedef struct packed {
    logic [COUNT_W-1:0] cnt;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

endpackage

FILE: src/lfu_if.sv
// Request and victim result channel interfaces.
interface lfu_req_if
  import lfu_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [SET_W-1:0]  set_index;
  logic [WAYF_W-1:0] way_index;
  logic              is_write;
  logic              was_hit;

  modport source (output valid, cmd, set_index, way_index, is_write, was_hit, input ready);
  modport sink   (input valid, cmd, set_index, way_index, is_write, was_hit, output ready);
endinterface

interface lfu_rsp_if
  import lfu_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [WAYF_W-1:0] victim_way;

  modport source (output valid, victim_way, input ready);
  modport sink   (input valid, victim_way, output ready);
endinterface

FILE: src/lfu_lru_tiebreak_replacement.sv
// Top level: LFU replacement with LRU tie-break, one shared compare unit under a sequencer.
// Victim search: one table read and one count/stamp compare per way, then the victim is
//   registered; the next request is taken only once the search ends and any pending result
//   has been taken, since requests are taken only in the idle state.
// Fill: one table write; access update: read, then modify-write; ignored requests: back to idle.
// After reset a clearing pass zeroes the table before the first request is taken;
//   the access clock resets to zero.
module lfu_lru_tiebreak_replacement
  import lfu_pkg::*;
#(
  parameter int SETS = 64,
  parameter int WAYS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lfu_req_if.sink   req_i,
  lfu_rsp_if.source rsp_o
);

  localparam int DEPTH  = SETS * WAYS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WAY_W  = $clog2(WAYS);

  state_e              state_q, state_d;
  logic [SET_W-1:0]    set_q, set_d;
  logic [WAYF_W-1:0]   way_q, way_d;
  logic                hit_q, hit_d;
  logic [WAY_W-1:0]    scan_way_q, scan_way_d;
  logic                cmp_en_q, cmp_en_d;
  logic [WAY_W-1:0]    cmp_way_q, cmp_way_d;
  logic [WAY_W-1:0]    best_way_q, best_way_d;
  logic [COUNT_W-1:0]  best_cnt_q, best_cnt_d;
  logic [STAMP_W-1:0]  best_stamp_q, best_stamp_d;
  logic [STAMP_W-1:0]  clock_q, clock_d;
  logic [ADDR_W-1:0]   clr_addr_q, clr_addr_d;
  logic                out_valid_q, out_valid_d;
  logic [WAYF_W-1:0]   victim_q;
  logic                load_out;

  entry_t              mem_q [DEPTH];
  entry_t              rdata_q;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [ADDR_W-1:0]   mem_raddr;
  entry_t              mem_wdata;

  logic [ADDR_W-1:0]   row_addr;
  logic [ADDR_W-1:0]   scan_addr;
  logic                in_set_ok;
  logic                in_way_ok;
  logic                take_new;

  assign row_addr  = ADDR_W'(32'(set_q) * 32'(WAYS) + 32'(way_q));
  assign scan_addr = ADDR_W'(32'(set_q) * 32'(WAYS) + 32'(scan_way_q));
  assign in_set_ok = 32'(req_i.set_index) < 32'(SETS);
  assign in_way_ok = 32'(req_i.way_index) < 32'(WAYS);

  assign take_new = (cmp_way_q == '0) || (rdata_q.cnt < best_cnt_q) ||
                    ((rdata_q.cnt == best_cnt_q) && (rdata_q.stamp < best_stamp_q));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[mem_raddr];
  end

  always_comb begin
    state_d      = state_q;
    set_d        = set_q;
    way_d        = way_q;
    hit_d        = hit_q;
    scan_way_d   = scan_way_q;
    cmp_en_d     = 1'b0;
    cmp_way_d    = cmp_way_q;
    best_way_d   = best_way_q;
    best_cnt_d   = best_cnt_q;
    best_stamp_d = best_stamp_q;
    clock_d      = clock_q;
    clr_addr_d   = clr_addr_q;
    mem_we       = 1'b0;
    mem_waddr    = row_addr;
    mem_raddr    = row_addr;
    mem_wdata    = '0;
    load_out     = 1'b0;
    req_i.ready  = 1'b0;

    if (cmp_en_q && take_new) begin
      best_way_d   = cmp_way_q;
      best_cnt_d   = rdata_q.cnt;
      best_stamp_d = rdata_q.stamp;
    end

    case (state_q)
      ST_CLEAR: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_addr_q;
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          set_d = req_i.set_index;
          way_d = req_i.way_index;
          hit_d = req_i.was_hit;
          case (req_i.cmd)
            CMD_VICTIM: begin
              if (in_set_ok) begin
                scan_way_d = '0;
                state_d    = ST_SCAN;
              end else begin
                best_way_d = '0;
                state_d    = ST_FINISH;
              end
            end
            CMD_FILL: begin
              if (in_set_ok && in_way_ok) begin
                state_d = ST_FILL;
              end
            end
            CMD_UPDATE: begin
              if (in_set_ok && in_way_ok && !req_i.is_write) begin
                state_d = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        mem_raddr  = scan_addr;
        cmp_en_d   = 1'b1;
        cmp_way_d  = scan_way_q;
        scan_way_d = scan_way_q + 1'b1;
        if (scan_way_q == WAY_W'(WAYS - 1)) begin
          state_d = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || rsp_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_FILL: begin
        mem_we          = 1'b1;
        mem_wdata.cnt   = COUNT_W'(1);
        mem_wdata.stamp = clock_q;
        state_d         = ST_IDLE;
      end
      ST_READ: begin
        state_d = ST_MODIFY;
      end
      ST_MODIFY: begin
        mem_we          = 1'b1;
        mem_wdata.cnt   = (hit_q && (rdata_q.cnt != '1)) ? rdata_q.cnt + 1'b1 : rdata_q.cnt;
        mem_wdata.stamp = clock_q;
        clock_d         = clock_q + 1'b1;
        state_d         = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_valid_d = (out_valid_q && !rsp_o.ready) || load_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      clock_q     <= '0;
      cmp_en_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      clock_q     <= clock_d;
      cmp_en_q    <= cmp_en_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    set_q        <= set_d;
    way_q        <= way_d;
    hit_q        <= hit_d;
    scan_way_q   <= scan_way_d;
    cmp_way_q    <= cmp_way_d;
    best_way_q   <= best_way_d;
    best_cnt_q   <= best_cnt_d;
    best_stamp_q <= best_stamp_d;
    if (load_out) begin
      victim_q <= WAYF_W'(best_way_q);
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.victim_way = victim_q;

endmodule

FILE: bench/tb_lfu_lru_tiebreak_replacement.sv
// Testbench for the LFU replacement block with LRU tie-break: directed table, then random requests.
module tb_lfu_lru_tiebreak_replacement;
  import lfu_pkg::*;

  localparam int NSETS = 64;
  localparam int NWAYS = 16;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1350;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [SET_W-1:0]  set_index;
    logic [WAYF_W-1:0] way_index;
    bit                is_write;
    bit                was_hit;
    bit                fixed;
    logic [WAYF_W-1:0] victim;
  } plan_row_t;

  localparam int PLAN_LEN = 23;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lfu_req_if req ();
  lfu_rsp_if rsp ();

  lfu_lru_tiebreak_replacement #(
    .SETS(NSETS),
    .WAYS(NWAYS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  always #5 clk_i = ~clk_i;

  logic [COUNT_W-1:0] use_cnt   [NSETS*NWAYS];
  logic [STAMP_W-1:0] use_stamp [NSETS*NWAYS];
  logic [STAMP_W-1:0] acc_clock;

  logic [WAYF_W-1:0] victim_q [$];
  int unsigned       mismatches = 0;
  bit                idle_en = 1'b1;
  bit                pin_fixed = 1'b0;
  logic [WAYF_W-1:0] pin_way = '0;
  int                stall_left = 0;

  plan_row_t plan [PLAN_LEN] = '{
    '{CMD_VICTIM, 6'd0,  4'd0,  1'b0, 1'b0, 1'b1, 4'd0},
    '{CMD_VICTIM, 6'd63, 4'd15, 1'b1, 1'b1, 1'b1, 4'd0},
    '{CMD_FILL,   6'd0,  4'd0,  1'b0, 1'b0, 1'b0, 4'd0},
    '{CMD_VICTIM, 6'd0,  4'd0,  1'b0, 1'b0, 1'b1, 4'd1},
    '{CMD_UPDATE, 6'd63, 4'd15, 1'b0, 1'b1, 1'b0, 4'd0},
    '{CMD_VICTIM, 6'd63, 4'd0,  1'b0, 1'b0, 1'b1, 4'd0},
    '{CMD_UPDATE, 6'd63, 4'd0,  1'b1, 1'b1, 1'b0, 4'd0},
    '{CMD_VICTIM, 6'd63, 4'd0,  1'b0, 1'b0, 1'b1, 4'd0},
    '{CMD_UNUSED, 6'd63, 4'd0,  1'b0, 1'b1, 1'b0, 4'd0},
    '{CMD_VICTIM, 6'd63, 4'd0,  1'b0, 1'b0, 1'b1, 4'd0},
    '{CMD_UPDATE, 6'd63, 4'd0,  1'b0, 1'b0, 1'b0, 4'd0},
    '{CMD_VICTIM, 6'd63, 4'd0,  1'b0, 1'b0, 1'b1, 4'd1},
    '{CMD_FILL,   6'd0,  4'd15, 1'b1, 1'b1, 1'b0, 4'd0},
    '{CMD_VICTIM, 6'd0,  4'd0,  1'b0, 1'b0, 1'b1, 4'd1},
    '{CMD_UPDATE, 6'd0,  4'd1,  1'b0, 1'b1, 1'b0, 4'd0},
    '{CMD_VICTIM, 6'd0,  4'd0,  1'b0, 1'b0, 1'b1, 4'd2},
    '{CMD_FILL,   6'd42, 4'd7,  1'b0, 1'b1, 1'b0, 4'd0},
    '{CMD_UPDATE, 6'd42, 4'd7,  1'b0, 1'b1, 1'b0, 4'd0},
    '{CMD_VICTIM, 6'd42, 4'd10, 1'b1, 1'b0, 1'b0, 4'd0},
    '{CMD_UPDATE, 6'd0,  4'd15, 1'b0, 1'b0, 1'b0, 4'd0},
    '{CMD_VICTIM, 6'd0,  4'd5,  1'b0, 1'b1, 1'b0, 4'd0},
    '{CMD_UNUSED, 6'd21, 4'd10, 1'b1, 1'b0, 1'b0, 4'd0},
    '{CMD_VICTIM, 6'd63, 4'd0,  1'b0, 1'b0, 1'b0, 4'd0}
  };

  function automatic logic [WAYF_W-1:0] step_policy(logic [CMD_W-1:0] cmd,
                                                    logic [SET_W-1:0] set_index,
                                                    logic [WAYF_W-1:0] way_index,
                                                    bit is_write, bit was_hit);
    int                 base;
    int                 idx;
    logic [WAYF_W-1:0]  best;
    logic [COUNT_W-1:0] best_cnt;
    logic [STAMP_W-1:0] best_stamp;
    base = int'(set_index) * NWAYS;
    idx  = base + int'(way_index);
    best = '0;
    case (cmd)
      CMD_VICTIM: begin
        best_cnt   = use_cnt[base];
        best_stamp = use_stamp[base];
        for (int w = 1; w < NWAYS; w++) begin
          if (use_cnt[base+w] < best_cnt ||
              (use_cnt[base+w] == best_cnt && use_stamp[base+w] < best_stamp)) begin
            best       = WAYF_W'(w);
            best_cnt   = use_cnt[base+w];
            best_stamp = use_stamp[base+w];
          end
        end
      end
      CMD_FILL: begin
        use_stamp[idx] = acc_clock;
        use_cnt[idx]   = 1;
      end
      CMD_UPDATE: begin
        if (!is_write) begin
          if (was_hit && use_cnt[idx] != '1) use_cnt[idx] = use_cnt[idx] + 1'b1;
          use_stamp[idx] = acc_clock;
          acc_clock      = acc_clock + 1'b1;
        end
      end
      default: ;
    endcase
    return best;
  endfunction

  initial begin
    for (int i = 0; i < NSETS*NWAYS; i++) begin
      use_cnt[i]   = '0;
      use_stamp[i] = '0;
    end
    acc_clock = '0;
  end

  always @(posedge clk_i) begin : monitor
    logic [WAYF_W-1:0] want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (victim_q.size() == 0) begin
        $error("victim_way: expected none, actual %0d", rsp.victim_way);
        mismatches++;
      end else begin
        want = victim_q.pop_front();
        if (rsp.victim_way !== want) begin
          $error("victim_way: expected %0d, actual %0d", want, rsp.victim_way);
          mismatches++;
        end
      end
    end
    if (rst_ni && req.valid && req.ready) begin
      want = step_policy(req.cmd, req.set_index, req.way_index, req.is_write, req.was_hit);
      if (req.cmd == CMD_VICTIM) victim_q.push_back(pin_fixed ? pin_way : want);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_left <= 0;
      rsp.ready  <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp.ready  <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 13);
      rsp.ready  <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  task automatic push_req(logic [CMD_W-1:0] cmd, logic [SET_W-1:0] set_index,
                          logic [WAYF_W-1:0] way_index, bit is_write, bit was_hit,
                          bit fixed, logic [WAYF_W-1:0] victim);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    req.valid     <= 1'b1;
    req.cmd       <= cmd;
    req.set_index <= set_index;
    req.way_index <= way_index;
    req.is_write  <= is_write;
    req.was_hit   <= was_hit;
    pin_fixed     <= fixed;
    pin_way       <= victim;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
  endtask

  initial begin : driver
    logic [SET_W-1:0]  hot [4];
    logic [CMD_W-1:0]  cmd;
    logic [SET_W-1:0]  set_index;
    bit                is_write;
    int                pick;
    int                effective;
    req.valid     = 1'b0;
    req.cmd       = CMD_VICTIM;
    req.set_index = '0;
    req.way_index = '0;
    req.is_write  = 1'b0;
    req.was_hit   = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i])
      push_req(plan[i].cmd, plan[i].set_index, plan[i].way_index, plan[i].is_write,
               plan[i].was_hit, plan[i].fixed, plan[i].victim);

    effective = 0;
    while (effective < RANDOM_ITEMS) begin
      if (effective % 150 == 0) begin
        foreach (hot[i]) hot[i] = SET_W'($urandom_range(0, NSETS-1));
      end
      idle_en = (effective < RANDOM_ITEMS - 200) && ((effective / 150) % 3 != 2);
      pick = $urandom_range(0, 99);
      if (pick < 25)      cmd = CMD_VICTIM;
      else if (pick < 50) cmd = CMD_FILL;
      else if (pick < 95) cmd = CMD_UPDATE;
      else                cmd = CMD_UNUSED;
      set_index = ($urandom_range(0, 4) != 0) ? hot[$urandom_range(0, 3)]
                                                : SET_W'($urandom_range(0, NSETS-1));
      is_write = ($urandom_range(0, 3) == 0);
      push_req(cmd, set_index, WAYF_W'($urandom_range(0, NWAYS-1)), is_write,
               ($urandom_range(0, 9) < 6), 1'b0, '0);
      effective++;
    end
    req.valid <= 1'b0;

    while (victim_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_lfu_lru_tiebreak_replacement: PASS");
    end else begin
      $display("tb_lfu_lru_tiebreak_replacement: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_lfu_lru_tiebreak_replacement: FAIL");
    $finish;
  end

endmodule

FILE: sim.f
src/lfu_pkg.sv
src/lfu_if.sv
src/lfu_lru_tiebreak_replacement.sv
bench/tb_lfu_lru_tiebreak_replacement.sv
